@@ rtl/afthp_pkg.sv @@
// Shared types and constants of the audio frame tile header parser.
package afthp_pkg;

    localparam int MASK_W         = 6;
    localparam int SAMP_W         = 15;
    localparam int LEN_W          = 16;
    localparam int GATH_W         = 8;
    localparam int PEND_W         = 4;
    localparam int CNT_RES_W      = 4;
    localparam int RESULT_CAP     = 8;
    localparam int LF_MIN         = 7;
    localparam int LF_MAX         = 14;
    localparam int LM_LIMIT       = 5;
    localparam int ZERO_FLAG_LM   = 4;
    localparam int ZERO_SUFFIX    = 3;
    localparam int SHIFT_LIMIT    = 31;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_DATA_W     = 4;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOG2_FRAME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG2_MAX_SUB  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSSLESS      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd3;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BIT   = 1'b1;

    typedef struct packed {
        logic [3:0] log2_frame_samples;
        logic [2:0] log2_max_subframes;
        logic       lossless_mode;
        logic [2:0] channel_count;
    } cfg_t;

    typedef struct packed {
        logic is_bit;
        logic bit_val;
    } cmd_t;

    typedef struct packed {
        logic [MASK_W-1:0] channel_mask;
        logic [SAMP_W-1:0] subframe_samples;
        logic              status;
        logic              frame_done;
        logic              last;
    } result_t;

endpackage

@@ rtl/audio_frame_tile_header_parser.sv @@
// Top level of the audio frame tile header parser: configuration registers and the three parts.
//
//  Channel   Ports                                        Accepted when
//  input     s_valid s_ready s_command s_stream_bit       s_valid && s_ready
//  result    m_valid m_ready m_channel_mask m_subframe_samples m_status m_frame_done m_last
//                                                         m_valid && m_ready
//  config    cfg_valid cfg_ready cfg_index cfg_data       cfg_valid && cfg_ready
//
//  A start item goes straight to the end state of the back part, or first emits its
//  single-subframe result; a bit that only extends a code passes through the loop state. Each parse
//  iteration runs the minimum search, channel mask, product and split check, and one that adds
//  a subframe then checks its length and updates the channel lanes one after another.
//  The front register and a two-entry queue take further items while the back part works.
//  Reset is synchronous and active low and clears all control state; there is no clearing pass.
//  A stalled result channel holds the back part once one result waits in the output register
//  and another in the hold register.
module audio_frame_tile_header_parser #(
    parameter int MAX_CHANNEL_COUNT  = 6,
    parameter int MAX_SUBFRAME_COUNT = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic                              s_stream_bit,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [afthp_pkg::MASK_W-1:0]      m_channel_mask,
    output logic [afthp_pkg::SAMP_W-1:0]      m_subframe_samples,
    output logic                              m_status,
    output logic                              m_frame_done,
    output logic                              m_last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [afthp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [afthp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    afthp_pkg::cfg_t    cfg_reg;
    logic               f_valid;
    logic               f_ready;
    afthp_pkg::cmd_t    f_data;
    logic               b_valid;
    logic               b_ready;
    afthp_pkg::cmd_t    b_data;
    afthp_pkg::result_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.log2_frame_samples <= 4'd11;
            cfg_reg.log2_max_subframes <= 3'd0;
            cfg_reg.lossless_mode      <= 1'b0;
            cfg_reg.channel_count      <= 3'd2;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                afthp_pkg::CFG_LOG2_FRAME:    cfg_reg.log2_frame_samples <= cfg_data[3:0];
                afthp_pkg::CFG_LOG2_MAX_SUB:  cfg_reg.log2_max_subframes <= cfg_data[2:0];
                afthp_pkg::CFG_LOSSLESS:      cfg_reg.lossless_mode      <= cfg_data[0];
                afthp_pkg::CFG_CHANNEL_COUNT: cfg_reg.channel_count      <= cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    afthp_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_stream_bit (s_stream_bit),
        .f_valid      (f_valid),
        .f_ready      (f_ready),
        .f_data       (f_data)
    );

    afthp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    afthp_back #(
        .MAX_CHANNEL_COUNT  (MAX_CHANNEL_COUNT),
        .MAX_SUBFRAME_COUNT (MAX_SUBFRAME_COUNT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (b_valid),
        .q_ready  (b_ready),
        .q_data   (b_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result)
    );

    assign m_channel_mask     = result.channel_mask;
    assign m_subframe_samples = result.subframe_samples;
    assign m_status           = result.status;
    assign m_frame_done       = result.frame_done;
    assign m_last             = result.last;

endmodule

@@ rtl/afthp_front.sv @@
// Input stage: accepts items and classifies them into start and bit commands.
module afthp_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_command,
    input  logic             s_stream_bit,
    output logic             f_valid,
    input  logic             f_ready,
    output afthp_pkg::cmd_t  f_data
);

    logic            valid_reg;
    afthp_pkg::cmd_t data_reg;

    assign s_ready = !valid_reg || f_ready;
    assign f_valid = valid_reg;
    assign f_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            data_reg.is_bit  <= (s_command == afthp_pkg::CMD_BIT);
            data_reg.bit_val <= s_stream_bit;
        end
    end

endmodule

@@ rtl/afthp_queue.sv @@
// Short command queue between the front and back parts.
module afthp_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  afthp_pkg::cmd_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output afthp_pkg::cmd_t  out_data
);

    localparam int PTR_W = (afthp_pkg::QUEUE_DEPTH > 1) ? $clog2(afthp_pkg::QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(afthp_pkg::QUEUE_DEPTH + 1);

    afthp_pkg::cmd_t    entry_reg [afthp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic               push;
    logic               pop;

    assign in_ready  = (fill_reg != FILL_W'(afthp_pkg::QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(afthp_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(afthp_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ rtl/afthp_back.sv @@
// Tiling sequencer: runs the parse iterations, keeps the channel state and drives results.
module afthp_back #(
    parameter int MAX_CHANNEL_COUNT  = 6,
    parameter int MAX_SUBFRAME_COUNT = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  afthp_pkg::cfg_t     cfg,
    input  logic                q_valid,
    output logic                q_ready,
    input  afthp_pkg::cmd_t     q_data,
    output logic                m_valid,
    input  logic                m_ready,
    output afthp_pkg::result_t  m_result
);

    localparam int NCH    = MAX_CHANNEL_COUNT;
    localparam int IW     = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int LW     = $clog2(NCH + 1);
    localparam int CNTW   = $clog2(MAX_SUBFRAME_COUNT + 1);
    localparam int LM_CAP = $clog2(MAX_SUBFRAME_COUNT + 1) - 1;
    localparam int MW     = $clog2(NCH * (1 << afthp_pkg::LF_MAX) + 1);
    localparam int LEN_W  = afthp_pkg::LEN_W;
    localparam int LR_W   = LEN_W + afthp_pkg::GATH_W + 1;
    localparam int PW     = LEN_W + LW;
    localparam int EW     = ((PW > MW) ? PW : MW) + 1;
    localparam int GW     = afthp_pkg::GATH_W;
    localparam int PDW    = afthp_pkg::PEND_W;
    localparam int SAMP_W_L = afthp_pkg::SAMP_W;

    typedef enum logic [3:0] {
        B_POP, B_LOOP, B_MIN, B_MASK, B_PROD, B_ACT, B_CHK, B_LANE, B_EMIT, B_END
    } bstate_t;

    typedef enum logic [2:0] {
        PH_IDLE, PH_FLAG, PH_DECIDE, PH_TILE, PH_ZERO, PH_LEN
    } phase_t;

    typedef enum logic [1:0] {
        CTX_PLAN, CTX_TILES, CTX_ADD
    } ctx_t;

    bstate_t             state_reg;
    phase_t              phase_reg;
    ctx_t                ctx_reg;
    logic [LEN_W-1:0]    chan_len_reg [NCH];
    logic [CNTW-1:0]     sub_cnt_reg  [NCH];
    logic [MW-1:0]       missing_reg;
    logic                single_reg;
    logic [GW-1:0]       gath_reg;
    logic [PDW-1:0]      pend_reg;
    logic [NCH-1:0]      tsel_reg;
    logic                have_bit_reg;
    logic                bit_reg;
    logic [afthp_pkg::CNT_RES_W-1:0] res_cnt_reg;
    logic [LEN_W-1:0]    min_reg;
    logic [NCH-1:0]      mask_reg;
    logic [LW-1:0]       k_reg;
    logic [PW-1:0]       prod_reg;
    logic [LR_W-1:0]     len_reg;
    logic [NCH-1:0]      addmask_reg;
    logic [NCH-1:0]      added_reg;
    logic [LW-1:0]       lane_reg;
    afthp_pkg::result_t  pend_res_reg;
    afthp_pkg::result_t  hold_reg;
    logic                hold_valid_reg;
    afthp_pkg::result_t  out_reg;
    logic                out_valid_reg;

    // Register values brought into their legal ranges.
    logic [3:0]          lf;
    logic [2:0]          lm;
    logic [LW-1:0]       chn;
    logic [LEN_W-1:0]    frame_w;
    logic [LEN_W-1:0]    s_v;

    always_comb begin
        if (cfg.log2_frame_samples < 4'(afthp_pkg::LF_MIN)) begin
            lf = 4'(afthp_pkg::LF_MIN);
        end else if (cfg.log2_frame_samples > 4'(afthp_pkg::LF_MAX)) begin
            lf = 4'(afthp_pkg::LF_MAX);
        end else begin
            lf = cfg.log2_frame_samples;
        end
        lm = (cfg.log2_max_subframes > 3'(afthp_pkg::LM_LIMIT)) ?
             3'(afthp_pkg::LM_LIMIT) : cfg.log2_max_subframes;
        if (lm > 3'(LM_CAP)) begin
            lm = 3'(LM_CAP);
        end
        if (cfg.channel_count == 3'd0) begin
            chn = LW'(1);
        end else if (int'(cfg.channel_count) > NCH) begin
            chn = LW'(NCH);
        end else begin
            chn = LW'(cfg.channel_count);
        end
        frame_w = LEN_W'(1) << lf;
        s_v     = frame_w >> lm;
    end

    // Minimum channel length, then the channels that sit at it.
    logic [LEN_W-1:0] min_v;
    logic [NCH-1:0]   eqmask;
    logic [LW-1:0]    kcnt;

    always_comb begin
        min_v = frame_w;
        for (int c = 0; c < NCH; c++) begin
            if (c < int'(chn) && chan_len_reg[c] < min_v) begin
                min_v = chan_len_reg[c];
            end
        end
    end

    always_comb begin
        eqmask = '0;
        kcnt   = '0;
        for (int c = 0; c < NCH; c++) begin
            if (c < int'(chn) && chan_len_reg[c] == min_reg) begin
                eqmask[c] = 1'b1;
                kcnt      = kcnt + 1'b1;
            end
        end
    end

    logic [LW-1:0] keff;
    logic          even;

    // The split is even when the nominal subframe length S equals the missing samples divided by k,
    // rounded down, that is when S*k <= missing < S*k + k.
    always_comb begin
        keff = single_reg ? chn : k_reg;
        if (keff == '0) begin
            keff = LW'(1);
        end
        even = (EW'(prod_reg) <= EW'(missing_reg)) &&
               (EW'(missing_reg) < EW'(prod_reg) + EW'(keff));
    end

    // The first gathered flag bit belongs to the lowest selected channel.
    logic [NCH-1:0] sel_v;
    logic [LW-1:0]  j_v;
    logic [GW-1:0]  shifted;

    always_comb begin
        sel_v   = '0;
        j_v     = '0;
        shifted = '0;
        for (int c = 0; c < NCH; c++) begin
            if (mask_reg[c]) begin
                j_v     = j_v + 1'b1;
                shifted = gath_reg >> (k_reg - j_v);
                if (shifted[0]) begin
                    sel_v[c] = 1'b1;
                end
            end
        end
    end

    logic [NCH-1:0] tail_sel;
    assign tail_sel = (ctx_reg == CTX_TILES) ? sel_v : mask_reg;

    // Bit consumption and the coded length.
    logic [GW-1:0]   g_new;
    logic [PDW-1:0]  p_dec;
    logic [GW:0]     vv;
    logic [LR_W-1:0] len_calc;

    always_comb begin
        g_new = {gath_reg[GW-2:0], bit_reg};
        p_dec = (pend_reg != '0) ? pend_reg - 1'b1 : '0;
        vv    = {1'b0, g_new};
        if (cfg.lossless_mode) begin
            len_calc = LR_W'(s_v) * LR_W'(vv + 1'b1);
        end else begin
            if (lm == 3'(afthp_pkg::ZERO_FLAG_LM)) begin
                vv = vv + 1'b1;
            end
            len_calc = (vv < (GW+1)'(afthp_pkg::SHIFT_LIMIT)) ? LR_W'(frame_w >> vv) : '0;
        end
    end

    // Per-channel update of the subframe being added.
    logic [IW-1:0]       li;
    logic [SAMP_W_L-1:0] len15;
    logic [LEN_W:0]      sum_v;

    assign li    = lane_reg[IW-1:0];
    assign len15 = len_reg[SAMP_W_L-1:0];
    assign sum_v = {1'b0, chan_len_reg[li]} + (LEN_W+1)'(len15);

    logic [NCH-1:0] all_mask;
    always_comb begin
        all_mask = '0;
        for (int c = 0; c < NCH; c++) begin
            if (c < int'(chn)) begin
                all_mask[c] = 1'b1;
            end
        end
    end

    localparam afthp_pkg::result_t FAIL_RES = '{
        channel_mask: '0, subframe_samples: '0, status: 1'b1, frame_done: 1'b0, last: 1'b0
    };

    // The output register is loaded from the hold register in this cycle.
    logic out_load;
    assign out_load = hold_valid_reg && (!out_valid_reg || m_ready) &&
                      ((state_reg == B_EMIT) || (state_reg == B_END));

    assign q_ready  = (state_reg == B_POP);
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= B_POP;
            phase_reg      <= PH_IDLE;
            ctx_reg        <= CTX_PLAN;
            missing_reg    <= '0;
            single_reg     <= 1'b0;
            gath_reg       <= '0;
            pend_reg       <= '0;
            tsel_reg       <= '0;
            have_bit_reg   <= 1'b0;
            res_cnt_reg    <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int c = 0; c < NCH; c++) begin
                chan_len_reg[c] <= '0;
                sub_cnt_reg[c]  <= '0;
            end
        end else begin
            if (out_valid_reg && m_ready && !out_load) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_POP: begin
                    if (q_valid) begin
                        res_cnt_reg <= '0;
                        bit_reg     <= q_data.bit_val;
                        if (!q_data.is_bit) begin
                            gath_reg     <= '0;
                            pend_reg     <= '0;
                            tsel_reg     <= '0;
                            single_reg   <= 1'b0;
                            have_bit_reg <= 1'b0;
                            missing_reg  <= MW'(chn) << lf;
                            for (int c = 0; c < NCH; c++) begin
                                chan_len_reg[c] <= '0;
                                sub_cnt_reg[c]  <= '0;
                            end
                            if (lm == 3'd0) begin
                                // A single subframe per channel needs no header bits.
                                for (int c = 0; c < NCH; c++) begin
                                    if (c < int'(chn)) begin
                                        chan_len_reg[c] <= frame_w;
                                        sub_cnt_reg[c]  <= CNTW'(1);
                                    end
                                end
                                missing_reg  <= '0;
                                phase_reg    <= PH_IDLE;
                                pend_res_reg <= '{
                                    channel_mask: afthp_pkg::MASK_W'(all_mask),
                                    subframe_samples: frame_w[SAMP_W_L-1:0],
                                    status: 1'b0, frame_done: 1'b1, last: 1'b0
                                };
                                state_reg    <= B_EMIT;
                            end else begin
                                phase_reg <= PH_FLAG;
                                state_reg <= B_END;
                            end
                        end else begin
                            have_bit_reg <= 1'b1;
                            state_reg    <= B_LOOP;
                        end
                    end
                end
                B_LOOP: begin
                    if (res_cnt_reg == afthp_pkg::CNT_RES_W'(afthp_pkg::RESULT_CAP)) begin
                        state_reg <= B_END;
                    end else if (phase_reg == PH_DECIDE) begin
                        ctx_reg   <= CTX_PLAN;
                        state_reg <= B_MIN;
                    end else if (!have_bit_reg || phase_reg == PH_IDLE) begin
                        state_reg <= B_END;
                    end else begin
                        have_bit_reg <= 1'b0;
                        unique case (phase_reg)
                            PH_FLAG: begin
                                single_reg <= bit_reg;
                                phase_reg  <= PH_DECIDE;
                            end
                            PH_TILE: begin
                                gath_reg <= g_new;
                                pend_reg <= p_dec;
                                if (p_dec == '0) begin
                                    ctx_reg   <= CTX_TILES;
                                    state_reg <= B_MIN;
                                end
                            end
                            PH_ZERO: begin
                                if (!bit_reg) begin
                                    len_reg   <= LR_W'(frame_w);
                                    ctx_reg   <= CTX_ADD;
                                    state_reg <= B_MIN;
                                end else begin
                                    gath_reg  <= '0;
                                    pend_reg  <= PDW'(afthp_pkg::ZERO_SUFFIX);
                                    phase_reg <= PH_LEN;
                                end
                            end
                            PH_LEN: begin
                                gath_reg <= g_new;
                                pend_reg <= p_dec;
                                if (p_dec == '0) begin
                                    len_reg   <= len_calc;
                                    ctx_reg   <= CTX_ADD;
                                    state_reg <= B_MIN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                B_MIN: begin
                    min_reg   <= min_v;
                    state_reg <= B_MASK;
                end
                B_MASK: begin
                    mask_reg  <= eqmask;
                    k_reg     <= kcnt;
                    state_reg <= B_PROD;
                end
                B_PROD: begin
                    prod_reg  <= PW'(s_v) * PW'(keff);
                    state_reg <= B_ACT;
                end
                B_ACT: begin
                    priority if (ctx_reg == CTX_ADD) begin
                        addmask_reg <= mask_reg & tsel_reg;
                        state_reg   <= B_CHK;
                    end else if (ctx_reg == CTX_PLAN && !single_reg &&
                                 k_reg > LW'(1) && !even) begin
                        gath_reg  <= '0;
                        pend_reg  <= PDW'(k_reg);
                        phase_reg <= PH_TILE;
                        state_reg <= B_LOOP;
                    end else begin
                        tsel_reg <= tail_sel;
                        if (even) begin
                            len_reg     <= LR_W'(s_v);
                            addmask_reg <= mask_reg & tail_sel;
                            state_reg   <= B_CHK;
                        end else begin
                            gath_reg  <= '0;
                            state_reg <= B_LOOP;
                            if (cfg.lossless_mode) begin
                                pend_reg  <= PDW'(lm);
                                phase_reg <= PH_LEN;
                            end else if (lm == 3'(afthp_pkg::ZERO_FLAG_LM)) begin
                                phase_reg <= PH_ZERO;
                            end else begin
                                pend_reg  <= PDW'(lm) + 1'b1;
                                phase_reg <= PH_LEN;
                            end
                        end
                    end
                end
                B_CHK: begin
                    if (len_reg < LR_W'(s_v) || len_reg > LR_W'(frame_w)) begin
                        pend_res_reg <= FAIL_RES;
                        phase_reg    <= PH_IDLE;
                        state_reg    <= B_EMIT;
                    end else begin
                        lane_reg  <= '0;
                        added_reg <= '0;
                        state_reg <= B_LANE;
                    end
                end
                B_LANE: begin
                    if (lane_reg >= chn) begin
                        pend_res_reg <= '{
                            channel_mask: afthp_pkg::MASK_W'(added_reg),
                            subframe_samples: len15,
                            status: 1'b0, frame_done: (missing_reg == '0), last: 1'b0
                        };
                        phase_reg <= (missing_reg == '0) ? PH_IDLE : PH_DECIDE;
                        state_reg <= B_EMIT;
                    end else if (!addmask_reg[li]) begin
                        lane_reg <= lane_reg + 1'b1;
                    end else if (sub_cnt_reg[li] >= CNTW'(MAX_SUBFRAME_COUNT)) begin
                        pend_res_reg <= FAIL_RES;
                        phase_reg    <= PH_IDLE;
                        state_reg    <= B_EMIT;
                    end else begin
                        chan_len_reg[li] <= sum_v[LEN_W-1:0];
                        sub_cnt_reg[li]  <= sub_cnt_reg[li] + 1'b1;
                        added_reg[li]    <= 1'b1;
                        lane_reg         <= lane_reg + 1'b1;
                        if (MW'(len15) > missing_reg) begin
                            missing_reg  <= '0;
                            pend_res_reg <= FAIL_RES;
                            phase_reg    <= PH_IDLE;
                            state_reg    <= B_EMIT;
                        end else begin
                            missing_reg <= missing_reg - MW'(len15);
                            if (sum_v > (LEN_W+1)'(frame_w)) begin
                                pend_res_reg <= FAIL_RES;
                                phase_reg    <= PH_IDLE;
                                state_reg    <= B_EMIT;
                            end
                        end
                    end
                end
                B_EMIT: begin
                    // A result is held back until the next one shows whether it is the last.
                    if (!hold_valid_reg) begin
                        hold_reg       <= pend_res_reg;
                        hold_valid_reg <= 1'b1;
                        res_cnt_reg    <= res_cnt_reg + 1'b1;
                        state_reg      <= B_LOOP;
                    end else if (!out_valid_reg || m_ready) begin
                        out_reg        <= hold_reg;
                        out_valid_reg  <= 1'b1;
                        hold_reg       <= pend_res_reg;
                        res_cnt_reg    <= res_cnt_reg + 1'b1;
                        state_reg      <= B_LOOP;
                    end
                end
                B_END: begin
                    if (!hold_valid_reg) begin
                        state_reg <= B_POP;
                    end else if (!out_valid_reg || m_ready) begin
                        out_reg        <= '{
                            channel_mask: hold_reg.channel_mask,
                            subframe_samples: hold_reg.subframe_samples,
                            status: hold_reg.status, frame_done: hold_reg.frame_done,
                            last: 1'b1
                        };
                        out_valid_reg  <= 1'b1;
                        hold_valid_reg <= 1'b0;
                        state_reg      <= B_POP;
                    end
                end
                default: begin
                    state_reg <= B_POP;
                end
            endcase
        end
    end

endmodule
